### hw/rtl/wrlm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrlm_pkg
// Shared constants, types and helpers for the windowed RMS level meter.
// ----------------------------------------------------------------------------
package wrlm_pkg;

	localparam int SAMPLE_SHIFT = 16;
	localparam int FRAC_SHIFT   = 16;
	localparam int MAX_WINDOW   = 65536;

	localparam int RAW_W  = 32;
	localparam int SMP_W  = RAW_W - SAMPLE_SHIFT;
	localparam int SQ_W   = 2 * SMP_W - 1;
	localparam int ACC_W  = 47;
	localparam int CNT_W  = 17;
	localparam int RMS_W  = 24;
	localparam int NUM_W  = ACC_W + FRAC_SHIFT;
	localparam int WORK_W = 2 * RMS_W;
	localparam int SREM_W = RMS_W + 2;

	localparam int DIV_STEPS  = NUM_W;
	localparam int SQRT_STEPS = RMS_W;
	localparam int STEP_W     = 6;

	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = 2;
	localparam int Q_LVL_W = 3;

	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// register index taken from paddr above the byte offset
	localparam logic REG_WINDOW_LENGTH = 1'b0;
	localparam logic [CNT_W-1:0] WINDOW_RESET = CNT_W'(1600);

	typedef struct packed {
		logic [ACC_W-1:0] sum;
		logic [CNT_W-1:0] count;
	} window_t;

	typedef struct packed {
		logic               empty;
		logic               full;
		logic [Q_LVL_W-1:0] level;
	} q_status_t;

	// zero means one sample, anything above the maximum saturates
	function automatic logic [CNT_W-1:0] eff_window(input logic [CNT_W-1:0] w);
		logic [CNT_W-1:0] r;
		r = w;
		if (w == '0) begin
			r = CNT_W'(1);
		end else if (w > CNT_W'(MAX_WINDOW)) begin
			r = CNT_W'(MAX_WINDOW);
		end
		return r;
	endfunction

endpackage

### hw/rtl/windowed_rms_level_meter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_rms_level_meter
// RMS level over a programmable window of 16-bit microphone samples.
// ----------------------------------------------------------------------------
// Samples are taken one per cycle while in_ready is high: the upper half of
// each raw word is squared and summed, and when the sample count reaches
// window_length (zero acts as one, values above 65536 saturate) the window's
// sum and count go into a four-entry queue and the accumulator restarts. A
// back end drains the queue and turns each window into floor(sqrt(sum *
// 65536 / count)), 8 fraction bits: a 63-step restoring divider followed by
// a 24-step square root in one shared unit. Windows longer than its time per
// result run at full sample rate while results are taken; shorter windows
// stall in_ready once the queue fills. A finished result waits in the output
// register without holding up the back end's next division.
// ----------------------------------------------------------------------------
module windowed_rms_level_meter (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [wrlm_pkg::ADDR_W-1:0]           paddr,
	input  logic [wrlm_pkg::DATA_W-1:0]           pwdata,
	output logic [wrlm_pkg::DATA_W-1:0]           prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic signed [wrlm_pkg::RAW_W-1:0]     raw_word,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [wrlm_pkg::RMS_W-1:0]            rms_level,
	output logic [wrlm_pkg::CNT_W-1:0]            samples_used
);

	logic [wrlm_pkg::CNT_W-1:0] window_q;
	logic [wrlm_pkg::CNT_W-1:0] window_eff;
	logic                       reg_idx;
	logic                       cfg_wr;

	logic                       push;
	logic                       pop;
	wrlm_pkg::window_t          push_data;
	wrlm_pkg::window_t          pop_data;
	wrlm_pkg::q_status_t        q_stat;

	assign pready  = 1'b1;
	assign reg_idx = paddr[wrlm_pkg::ADDR_W-1];
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign prdata  = (reg_idx == wrlm_pkg::REG_WINDOW_LENGTH)
	               ? wrlm_pkg::DATA_W'(window_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= wrlm_pkg::WINDOW_RESET;
		end else if (cfg_wr && reg_idx == wrlm_pkg::REG_WINDOW_LENGTH) begin
			window_q <= pwdata[wrlm_pkg::CNT_W-1:0];
		end
	end

	assign window_eff = wrlm_pkg::eff_window(window_q);

	wrlm_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.raw_word   (raw_word),
		.window_eff (window_eff),
		.q_stat     (q_stat),
		.push       (push),
		.push_data  (push_data)
	);

	wrlm_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (pop_data),
		.q_stat    (q_stat)
	);

	wrlm_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_stat       (q_stat),
		.pop_data     (pop_data),
		.pop          (pop),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.rms_level    (rms_level),
		.samples_used (samples_used)
	);

	// a closed window never finds the queue full
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!q_stat.full || pop))
		else $error("window pushed into full queue");

	// the back end never takes from an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("pop from empty queue");

	// results stay within full-scale root and a legal window size
	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rms_level <= wrlm_pkg::RMS_W'(8388608)
		               && samples_used != '0
		               && samples_used <= wrlm_pkg::CNT_W'(wrlm_pkg::MAX_WINDOW)))
		else $error("result out of range");

endmodule

### hw/rtl/wrlm_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrlm_front
// Squares each sample and accumulates it; hands closed windows to the queue.
// ----------------------------------------------------------------------------
module wrlm_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [wrlm_pkg::RAW_W-1:0] raw_word,
	input  logic [wrlm_pkg::CNT_W-1:0]        window_eff,
	input  wrlm_pkg::q_status_t               q_stat,
	output logic                             push,
	output wrlm_pkg::window_t                 push_data
);

	logic signed [wrlm_pkg::SMP_W-1:0]   sample;
	logic signed [2*wrlm_pkg::SMP_W-1:0] prod;
	logic [wrlm_pkg::Q_LVL_W-1:0]        lvl_sum;
	logic                                accept;

	logic                         valid_s1;
	logic [wrlm_pkg::SQ_W-1:0]    sq_s1;
	logic [wrlm_pkg::ACC_W-1:0]   acc_q;
	logic [wrlm_pkg::CNT_W-1:0]   cnt_q;
	logic [wrlm_pkg::ACC_W-1:0]   acc_next;
	logic [wrlm_pkg::CNT_W-1:0]   cnt_next;
	logic                         close;

	assign sample = raw_word[wrlm_pkg::RAW_W-1:wrlm_pkg::SAMPLE_SHIFT];
	assign prod   = sample * sample;

	// leave room for the item already in the square stage
	assign lvl_sum  = q_stat.level + wrlm_pkg::Q_LVL_W'(valid_s1);
	assign in_ready = lvl_sum < wrlm_pkg::Q_LVL_W'(wrlm_pkg::Q_DEPTH);
	assign accept   = in_valid && in_ready;

	assign acc_next = acc_q + wrlm_pkg::ACC_W'(sq_s1);
	assign cnt_next = cnt_q + wrlm_pkg::CNT_W'(1);
	assign close    = valid_s1 && (cnt_next >= window_eff);

	assign push            = close;
	assign push_data.sum   = acc_next;
	assign push_data.count = cnt_next;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			acc_q    <= '0;
			cnt_q    <= '0;
		end else begin
			valid_s1 <= accept;
			if (valid_s1) begin
				if (close) begin
					acc_q <= '0;
					cnt_q <= '0;
				end else begin
					acc_q <= acc_next;
					cnt_q <= cnt_next;
				end
			end
		end
	end

	// square of a 16-bit sample never sets the top product bit
	always_ff @(posedge clk) begin
		if (accept) begin
			sq_s1 <= prod[wrlm_pkg::SQ_W-1:0];
		end
	end

endmodule

### hw/rtl/wrlm_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrlm_queue
// Short queue of closed windows between the accumulator and the math unit.
// ----------------------------------------------------------------------------
module wrlm_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  wrlm_pkg::window_t   push_data,
	input  logic                pop,
	output wrlm_pkg::window_t   pop_data,
	output wrlm_pkg::q_status_t q_stat
);

	wrlm_pkg::window_t              mem_q [wrlm_pkg::Q_DEPTH];
	logic [wrlm_pkg::Q_PTR_W-1:0]   wr_ptr_q;
	logic [wrlm_pkg::Q_PTR_W-1:0]   rd_ptr_q;
	logic [wrlm_pkg::Q_LVL_W-1:0]   level_q;

	assign pop_data     = mem_q[rd_ptr_q];
	assign q_stat.level = level_q;
	assign q_stat.empty = level_q == '0;
	assign q_stat.full  = level_q == wrlm_pkg::Q_LVL_W'(wrlm_pkg::Q_DEPTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + wrlm_pkg::Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + wrlm_pkg::Q_PTR_W'(1);
			end
			if (push && !pop) begin
				level_q <= level_q + wrlm_pkg::Q_LVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - wrlm_pkg::Q_LVL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

### hw/rtl/wrlm_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wrlm_back
// Radix-2 divider and bit-serial square root producing the RMS result.
// ----------------------------------------------------------------------------
module wrlm_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wrlm_pkg::q_status_t         q_stat,
	input  wrlm_pkg::window_t           pop_data,
	output logic                        pop,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [wrlm_pkg::RMS_W-1:0]  rms_level,
	output logic [wrlm_pkg::CNT_W-1:0]  samples_used
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_SQRT,
		ST_DONE
	} state_t;

	state_t                          state_q;
	logic [wrlm_pkg::STEP_W-1:0]     step_q;
	logic [wrlm_pkg::NUM_W-1:0]      num_q;
	logic [wrlm_pkg::CNT_W-1:0]      div_q;
	logic [wrlm_pkg::CNT_W-1:0]      drem_q;
	logic [wrlm_pkg::WORK_W-1:0]     work_q;
	logic [wrlm_pkg::RMS_W-1:0]      root_q;
	logic [wrlm_pkg::SREM_W-1:0]     srem_q;
	logic                            out_valid_q;
	logic [wrlm_pkg::RMS_W-1:0]      rms_q;
	logic [wrlm_pkg::CNT_W-1:0]      used_q;

	logic [wrlm_pkg::CNT_W:0]        dr_shift;
	logic                            d_ge;
	logic [wrlm_pkg::CNT_W:0]        dr_sub;
	logic [wrlm_pkg::SREM_W+1:0]     sr_shift;
	logic [wrlm_pkg::SREM_W+1:0]     trial;
	logic                            s_ge;
	logic [wrlm_pkg::SREM_W+1:0]     sr_sub;
	logic                            out_free;

	assign pop      = (state_q == ST_IDLE) && !q_stat.empty;
	assign out_free = !out_valid_q || out_ready;

	// restoring divide step
	always_comb begin
		dr_shift = {drem_q, num_q[wrlm_pkg::NUM_W-1]};
		d_ge     = dr_shift >= {1'b0, div_q};
		dr_sub   = dr_shift - {1'b0, div_q};
	end

	// square root step, two radicand bits per step
	always_comb begin
		sr_shift = {srem_q, work_q[wrlm_pkg::WORK_W-1 -: 2]};
		trial    = {2'b00, root_q, 2'b01};
		s_ge     = sr_shift >= trial;
		sr_sub   = sr_shift - trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			num_q       <= '0;
			div_q       <= '0;
			drem_q      <= '0;
			work_q      <= '0;
			root_q      <= '0;
			srem_q      <= '0;
			out_valid_q <= 1'b0;
			rms_q       <= '0;
			used_q      <= '0;
		end else begin
			// a new result may load in the same cycle the old one transfers
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						num_q   <= {pop_data.sum, wrlm_pkg::FRAC_SHIFT'(0)};
						div_q   <= pop_data.count;
						drem_q  <= '0;
						work_q  <= '0;
						step_q  <= '0;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					drem_q <= d_ge ? dr_sub[wrlm_pkg::CNT_W-1:0]
					               : dr_shift[wrlm_pkg::CNT_W-1:0];
					num_q  <= {num_q[wrlm_pkg::NUM_W-2:0], 1'b0};
					work_q <= {work_q[wrlm_pkg::WORK_W-2:0], d_ge};
					if (step_q == wrlm_pkg::STEP_W'(wrlm_pkg::DIV_STEPS - 1)) begin
						step_q  <= '0;
						root_q  <= '0;
						srem_q  <= '0;
						state_q <= ST_SQRT;
					end else begin
						step_q <= step_q + wrlm_pkg::STEP_W'(1);
					end
				end
				ST_SQRT: begin
					srem_q <= s_ge ? sr_sub[wrlm_pkg::SREM_W-1:0]
					               : sr_shift[wrlm_pkg::SREM_W-1:0];
					root_q <= {root_q[wrlm_pkg::RMS_W-2:0], s_ge};
					work_q <= {work_q[wrlm_pkg::WORK_W-3:0], 2'b00};
					if (step_q == wrlm_pkg::STEP_W'(wrlm_pkg::SQRT_STEPS - 1)) begin
						step_q  <= '0;
						state_q <= ST_DONE;
					end else begin
						step_q <= step_q + wrlm_pkg::STEP_W'(1);
					end
				end
				ST_DONE: begin
					if (out_free) begin
						rms_q   <= root_q;
						used_q  <= div_q;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign rms_level    = rms_q;
	assign samples_used = used_q;

endmodule

### dv/windowed_rms_level_meter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_rms_level_meter_tb
// Self-checking bench for the windowed RMS level meter.
// ----------------------------------------------------------------------------
// Microphone words go in over a valid/ready channel, and the window length is
// programmed and read back over the register port. A bit-exact predictor
// runs on every accepted word and queues the expected window results. Each
// result transfer is compared with the oldest queued result. The run covers
// directed corner cases, a saturated window length, random traffic under
// several idle and stall mixes, and a long output hold that backs up the
// block until it stops taking input.
// ----------------------------------------------------------------------------
module windowed_rms_level_meter_tb;

	localparam int     SETTLE_CYCLES = 200;
	localparam longint CYCLE_LIMIT   = 2_000_000;
	localparam logic [wrlm_pkg::ADDR_W-1:0] WINDOW_ADDR =
		wrlm_pkg::ADDR_W'(4 * wrlm_pkg::REG_WINDOW_LENGTH);

	typedef struct packed {
		logic [wrlm_pkg::RMS_W-1:0] level;
		logic [wrlm_pkg::CNT_W-1:0] used;
	} rms_result_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               psel = 1'b0;
	logic                               penable = 1'b0;
	logic                               pwrite = 1'b0;
	logic [wrlm_pkg::ADDR_W-1:0]        paddr = '0;
	logic [wrlm_pkg::DATA_W-1:0]        pwdata = '0;
	logic [wrlm_pkg::DATA_W-1:0]        prdata;
	logic                               pready;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic signed [wrlm_pkg::RAW_W-1:0]  raw_word = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic [wrlm_pkg::RMS_W-1:0]         rms_level;
	logic [wrlm_pkg::CNT_W-1:0]         samples_used;

	// predictor state
	logic [wrlm_pkg::ACC_W-1:0] meter_sum = '0;
	logic [wrlm_pkg::CNT_W-1:0] meter_count = '0;
	logic [wrlm_pkg::CNT_W-1:0] meter_window = wrlm_pkg::WINDOW_RESET;
	rms_result_t                pending_levels[$];

	int     send_idle_pct = 0;
	int     stall_pct = 0;
	int     hold_request = 0;
	int     hold_left = 0;
	int     mismatch_count = 0;
	longint cycle_count = 0;

	windowed_rms_level_meter uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.raw_word     (raw_word),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.rms_level    (rms_level),
		.samples_used (samples_used)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic note_failure(input string what);
		mismatch_count++;
		if (mismatch_count <= 10) begin
			$display("%s", what);
		end
	endtask

	// largest r with r*r <= v, one bit at a time from the top
	function automatic logic [63:0] floor_root(input logic [63:0] v);
		logic [63:0] r;
		logic [63:0] trial;
		r = '0;
		for (int i = 31; i >= 0; i--) begin
			trial = r | (64'd1 << i);
			if (trial * trial <= v) begin
				r = trial;
			end
		end
		return r;
	endfunction

	function automatic void predict_window(input logic [wrlm_pkg::RAW_W-1:0] w);
		logic signed [15:0]         s;
		logic [63:0]                mag;
		logic [wrlm_pkg::CNT_W-1:0] span;
		logic [63:0]                mean;
		rms_result_t                res;
		s = w[31:16];
		mag = (s < 0) ? 64'(-int'(s)) : 64'(s);
		span = meter_window;
		if (span == '0) begin
			span = wrlm_pkg::CNT_W'(1);
		end else if (span > wrlm_pkg::CNT_W'(wrlm_pkg::MAX_WINDOW)) begin
			span = wrlm_pkg::CNT_W'(wrlm_pkg::MAX_WINDOW);
		end
		meter_sum = meter_sum + wrlm_pkg::ACC_W'(mag * mag);
		meter_count = meter_count + wrlm_pkg::CNT_W'(1);
		if (meter_count != '0 && meter_count >= span) begin
			mean = {1'b0, meter_sum, 16'b0} / 64'(meter_count);
			res.level = wrlm_pkg::RMS_W'(floor_root(mean));
			res.used = meter_count;
			pending_levels.push_back(res);
			meter_sum = '0;
			meter_count = '0;
		end
	endfunction

	task automatic send_word(input logic [wrlm_pkg::RAW_W-1:0] w);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		raw_word <= w;
		do @(posedge clk); while (!in_ready);
		predict_window(w);
	endtask

	task automatic wait_drained();
		while (pending_levels.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic check_window_reg();
		logic [wrlm_pkg::DATA_W-1:0] readback;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= WINDOW_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		readback = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		if (readback !== wrlm_pkg::DATA_W'(meter_window)) begin
			note_failure($sformatf("window_length read: expected %0d, got %0d",
				meter_window, readback));
		end
	endtask

	// only touches the register once nothing is in flight
	task automatic write_window(input logic [wrlm_pkg::DATA_W-1:0] value);
		in_valid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= WINDOW_ADDR;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		meter_window = value[wrlm_pkg::CNT_W-1:0];
		check_window_reg();
	endtask

	function automatic logic [wrlm_pkg::RAW_W-1:0] random_word();
		logic signed [15:0] s;
		s = 16'(int'($urandom_range(400)) - 200);
		case ($urandom_range(9)) inside
			0: return {16'h8000, 16'($urandom)};
			1: return {16'h7FFF, 16'($urandom)};
			[2:3]: return {s, 16'($urandom)};
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [wrlm_pkg::DATA_W-1:0] random_window();
		case ($urandom_range(7)) inside
			0: return '0;
			1: return 1;
			[2:4]: return $urandom_range(2, 8);
			5: return $urandom_range(9, 64);
			6: return $urandom_range(65, 300);
			default: return $urandom_range(65536, 131071);
		endcase
	endfunction

	// result side: random stalls, plus long holds on request
	always @(posedge clk) begin
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		rms_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_levels.size() == 0) begin
				note_failure($sformatf("unexpected result: rms %0d used %0d",
					rms_level, samples_used));
			end else begin
				want = pending_levels.pop_front();
				if (rms_level !== want.level || samples_used !== want.used) begin
					note_failure($sformatf("result: expected rms %0d used %0d, got rms %0d used %0d",
						want.level, want.used, rms_level, samples_used));
				end
			end
		end
	end

	task automatic test_register_reset();
		check_window_reg();
	endtask

	task automatic test_directed_cases();
		logic [wrlm_pkg::RAW_W-1:0] corner[9];
		corner = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 32'h0000_FFFF,
			32'hFFFF_0000, 32'hFFFF_FFFF, 32'h0001_0000, 32'h5555_AAAA, 32'hAAAA_5555};
		send_idle_pct = 0;
		stall_pct = 0;
		write_window(1);
		foreach (corner[i]) begin
			send_word(corner[i]);
		end
		// zero behaves as a one-sample window
		write_window(0);
		send_word(32'h8000_1234);
		send_word(32'h0003_0000);
		write_window(3);
		send_word(32'h7FFF_0000);
		send_word(32'h8000_0000);
		send_word(32'h0000_0001);
		// shorten an open window: it closes on the next sample with the real count
		write_window(65536);
		repeat (5) send_word(random_word());
		write_window(2);
		send_word(32'hC000_0000);
		send_word(32'h4000_0000);
		send_word(32'hFFFE_0000);
	endtask

	// all-ones write saturates to the maximum window; full-scale samples
	// then a shorter window closes it with the real count
	task automatic test_saturated_window();
		send_idle_pct = 0;
		stall_pct = 0;
		write_window(32'hFFFF_FFFF);
		repeat (40) send_word({16'h8000, 16'($urandom)});
		write_window(3);
		send_word({16'h8000, 16'($urandom)});
	endtask

	task automatic test_random_traffic();
		int idle_mix[4];
		int stall_mix[4];
		idle_mix = '{0, 51, 0, 37};
		stall_mix = '{0, 0, 51, 37};
		for (int m = 0; m < 4; m++) begin
			send_idle_pct = idle_mix[m];
			stall_pct = stall_mix[m];
			repeat (6) begin
				write_window(random_window());
				repeat (50) send_word(random_word());
			end
		end
	endtask

	// receiver holds off while words keep coming, so the block fills and stalls
	task automatic test_output_backpressure();
		send_idle_pct = 0;
		stall_pct = 0;
		write_window(1);
		hold_request = 1500;
		repeat (40) send_word(random_word());
		write_window(2);
		stall_pct = 51;
		hold_request = 800;
		repeat (40) send_word(random_word());
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_register_reset();
		test_directed_cases();
		test_saturated_window();
		test_random_traffic();
		test_output_backpressure();
		in_valid <= 1'b0;
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

### filelist.f
hw/rtl/wrlm_pkg.sv
hw/rtl/wrlm_front.sv
hw/rtl/wrlm_queue.sv
hw/rtl/wrlm_back.sv
hw/rtl/windowed_rms_level_meter.sv
dv/windowed_rms_level_meter_tb.sv
